// ===== design/lip_pkg.sv =====
package lip_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_W      = 32;
  localparam int THR_W      = 21;
  localparam int NUM_COORDS = 8;

  localparam int A_W     = COORD_BITS + 1;
  localparam int P_W     = 2 * COORD_BITS;
  localparam int C_W     = P_W + 1;
  localparam int DET_W   = 2 * A_W + 1;
  localparam int NUM_W   = C_W + A_W + 1;
  localparam int Q_W     = NUM_W + FRAC_BITS;
  localparam int DIV_LAT = Q_W + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] num_x;
    logic signed [NUM_W-1:0] num_y;
    logic signed [DET_W-1:0] det;
  } front_t;

  typedef struct packed {
    logic vld;
    logic par;
  } ctl_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             clip;
  } div_res_t;

endpackage

// ===== design/lip_front.sv =====
module lip_front (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic                                        valid_i,
  input  lip_pkg::coord_t [lip_pkg::NUM_COORDS-1:0]   coord_i,
  output logic                                        valid_o,
  output lip_pkg::front_t                             front_o
);
  import lip_pkg::*;

  logic [3:0] vld_q;

  logic signed [A_W-1:0]   a1_q, b1_q, a2_q, b2_q;
  logic signed [A_W-1:0]   a1_2q, b1_2q, a2_2q, b2_2q;
  logic signed [P_W-1:0]   p1_q, p2_q, p3_q, p4_q;
  logic signed [C_W-1:0]   c1_q, c2_q;
  logic signed [DET_W-1:0] dp1_q, dp2_q, det_q;
  logic signed [NUM_W-1:0] nx1_q, nx2_q, ny1_q, ny2_q;
  front_t                  front_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // coefficients and cross products of the end points
      a1_q <= A_W'(coord_i[3]) - A_W'(coord_i[1]);
      b1_q <= A_W'(coord_i[0]) - A_W'(coord_i[2]);
      a2_q <= A_W'(coord_i[7]) - A_W'(coord_i[5]);
      b2_q <= A_W'(coord_i[4]) - A_W'(coord_i[6]);
      p1_q <= P_W'(coord_i[2]) * P_W'(coord_i[1]);
      p2_q <= P_W'(coord_i[0]) * P_W'(coord_i[3]);
      p3_q <= P_W'(coord_i[6]) * P_W'(coord_i[5]);
      p4_q <= P_W'(coord_i[4]) * P_W'(coord_i[7]);
      // c terms and determinant products
      c1_q  <= C_W'(p1_q) - C_W'(p2_q);
      c2_q  <= C_W'(p3_q) - C_W'(p4_q);
      dp1_q <= DET_W'(a1_q) * DET_W'(b2_q);
      dp2_q <= DET_W'(a2_q) * DET_W'(b1_q);
      a1_2q <= a1_q;
      b1_2q <= b1_q;
      a2_2q <= a2_q;
      b2_2q <= b2_q;
      // determinant and numerator products
      det_q <= dp1_q - dp2_q;
      nx1_q <= NUM_W'(c2_q) * NUM_W'(b1_2q);
      nx2_q <= NUM_W'(c1_q) * NUM_W'(b2_2q);
      ny1_q <= NUM_W'(c1_q) * NUM_W'(a2_2q);
      ny2_q <= NUM_W'(c2_q) * NUM_W'(a1_2q);
      front_q.num_x <= nx1_q - nx2_q;
      front_q.num_y <= ny1_q - ny2_q;
      front_q.det   <= det_q;
    end
  end

  assign valid_o = vld_q[3];
  assign front_o = front_q;

endmodule

// ===== design/lip_div.sv =====
module lip_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [lip_pkg::NUM_W-1:0]  num_i,
  input  logic signed [lip_pkg::DET_W-1:0]  den_i,
  output lip_pkg::div_res_t                 res_o
);
  import lip_pkg::*;

  logic [Q_W-1:0]   n_q [Q_W+1];
  logic [Q_W-1:0]   q_q [Q_W+1];
  logic [DET_W-1:0] r_q [Q_W+1];
  logic [DET_W-1:0] d_q [Q_W+1];
  logic             neg_q [Q_W+1];

  logic [NUM_W-1:0] num_abs;
  logic [DET_W-1:0] den_abs;

  logic [DET_W:0]   rem2;
  logic [Q_W:0]     q_rnd, lim, mag;
  logic             clip;
  div_res_t         res_q;

  assign num_abs = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign den_abs = den_i[DET_W-1] ? DET_W'(-den_i) : DET_W'(den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]   <= Q_W'(num_abs) << FRAC_BITS;
      q_q[0]   <= '0;
      r_q[0]   <= '0;
      d_q[0]   <= den_abs;
      neg_q[0] <= num_i[NUM_W-1] ^ den_i[DET_W-1];
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic [DET_W:0] rr;
    logic           ge;
    assign rr = {r_q[i], n_q[i][Q_W-1]};
    assign ge = rr >= {1'b0, d_q[i]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i+1]   <= n_q[i] << 1;
        q_q[i+1]   <= {q_q[i][Q_W-2:0], ge};
        r_q[i+1]   <= ge ? DET_W'(rr - {1'b0, d_q[i]}) : rr[DET_W-1:0];
        d_q[i+1]   <= d_q[i];
        neg_q[i+1] <= neg_q[i];
      end
    end
  end

  // round half away from zero, then saturate
  always_comb begin
    rem2  = {r_q[Q_W], 1'b0};
    q_rnd = {1'b0, q_q[Q_W]} + (Q_W+1)'(rem2 >= {1'b0, d_q[Q_W]});
    lim   = neg_q[Q_W] ? ((Q_W+1)'(1) << (OUT_W-1))
                       : ((Q_W+1)'(1) << (OUT_W-1)) - (Q_W+1)'(1);
    clip  = q_rnd > lim;
    mag   = clip ? lim : q_rnd;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.value <= neg_q[Q_W] ? OUT_W'(-mag[OUT_W-1:0]) : mag[OUT_W-1:0];
      res_q.clip  <= clip;
    end
  end

  assign res_o = res_q;

endmodule

// ===== design/line_intersection_point_unit.sv =====
// channel | dir | tdata                              | tuser
// s_axis  | in  | 8 x 16b coords, line a then line b | -
// m_axis  | out | cross_x, cross_y (32b each)        | point_valid, clipped
// cfg     | in  | parallel_threshold (21b)           | -
// one request per cycle unless m_axis stalls; the front end feeds the one-bit-per-stage
// quotient pipeline (quotient width plus input and round stages)
// reset clears valid bits and sets the threshold to 1
// a stall at m_axis freezes the whole pipeline; tready follows the output slot
module line_intersection_point_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [20:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // a_x1, a_y1, a_x2, a_y2, b_x1, b_y1, b_x2, b_y2
  input  logic [127:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // cross_x, cross_y
  output logic [63:0]  m_axis_tdata_o,
  // point_valid, clipped
  output logic [1:0]   m_axis_tuser_o
);
  import lip_pkg::*;

  logic [THR_W-1:0]            thr_q;
  logic                        en;
  coord_t [NUM_COORDS-1:0]     coords;
  logic                        front_vld;
  front_t                      front;
  logic [DET_W-1:0]            det_abs;
  logic                        par;
  ctl_t                        ctl_q [DIV_LAT];
  div_res_t                    res_x, res_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign en = !ctl_q[DIV_LAT-1].vld || m_axis_tready_i;
  assign s_axis_tready_o = en;

  for (genvar i = 0; i < NUM_COORDS; i++) begin : g_coord
    assign coords[i] = s_axis_tdata_i[i*COORD_BITS +: COORD_BITS];
  end

  lip_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .coord_i (coords),
    .valid_o (front_vld),
    .front_o (front)
  );

  assign det_abs = front.det[DET_W-1] ? DET_W'(-front.det) : DET_W'(front.det);
  assign par     = (front.det == '0) || (det_abs < DET_W'(thr_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (en) begin
      ctl_q[0] <= '{vld: front_vld, par: par};
      for (int i = 1; i < DIV_LAT; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  lip_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (front.num_x),
    .den_i (front.det),
    .res_o (res_x)
  );

  lip_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (front.num_y),
    .den_i (front.det),
    .res_o (res_y)
  );

  assign m_axis_tvalid_o = ctl_q[DIV_LAT-1].vld;
  assign m_axis_tdata_o  = ctl_q[DIV_LAT-1].par ? '0 : {res_y.value, res_x.value};
  assign m_axis_tuser_o  = ctl_q[DIV_LAT-1].par ? 2'b00
                                                : {res_x.clip | res_y.clip, 1'b1};

endmodule

// ===== design/lip_checker.sv =====
module lip_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [63:0]  m_axis_tdata_o,
  input logic [1:0]   m_axis_tuser_o
);

  // parallel result carries a zero point and no clip flag
  a_par_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == '0 && !m_axis_tuser_o[1])
    else $error("parallel result not zero");

  // an empty output slot never blocks input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output");

  // a stalled output stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // a stall at the output stops input at once
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken during output stall");

endmodule

bind line_intersection_point_unit lip_checker u_lip_checker (.*);

// ===== tb/sv/line_intersection_point_unit_tb.sv =====
`timescale 1ns / 100ps

module line_intersection_point_unit_tb;
  import lip_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [OUT_W-1:0] cross_x;
    logic [OUT_W-1:0] cross_y;
    logic             point_valid;
    logic             clipped;
  } crossing_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [20:0]  cfg_wdata_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [63:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  crossing_t   pending_points[$];
  logic [20:0] threshold;
  int          fail_count;
  longint      cycle_count;
  bit          send_gaps;
  bit          recv_gaps;

  line_intersection_point_unit DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // rounded, saturated quotient of num * 2^FRAC_BITS by den
  function automatic logic [OUT_W-1:0] fixed_quotient(input logic signed [127:0] num,
                                                      input logic signed [127:0] den,
                                                      inout logic clip);
    logic          neg;
    logic [127:0]  n;
    logic [127:0]  d;
    logic [127:0]  q;
    logic [127:0]  r;
    logic [127:0]  lim;
    neg = num[127] ^ den[127];
    n = num[127] ? -num : num;
    d = den[127] ? -den : den;
    n = n << FRAC_BITS;
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) begin
      clip = 1'b1;
      q = lim;
    end
    fixed_quotient = neg ? -q[OUT_W-1:0] : q[OUT_W-1:0];
  endfunction

  function automatic crossing_t predict_crossing(input logic [127:0] pts);
    logic signed [127:0] c[8];
    logic signed [127:0] a1, b1, c1, a2, b2, c2, det, mag;
    crossing_t           res;
    logic                clip;
    for (int i = 0; i < 8; i++) c[i] = $signed(pts[16*i +: 16]);
    a1 = c[3] - c[1];
    b1 = c[0] - c[2];
    c1 = c[2] * c[1] - c[0] * c[3];
    a2 = c[7] - c[5];
    b2 = c[4] - c[6];
    c2 = c[6] * c[5] - c[4] * c[7];
    det = a1 * b2 - a2 * b1;
    mag = det < 0 ? -det : det;
    res = '{default: '0};
    clip = 1'b0;
    if (det != 0 && mag >= threshold) begin
      res.cross_x = fixed_quotient(c2 * b1 - c1 * b2, det, clip);
      res.cross_y = fixed_quotient(c1 * a2 - c2 * a1, det, clip);
      res.point_valid = 1'b1;
      res.clipped = clip;
    end
    return res;
  endfunction

  task automatic random_gap(input bit enable);
    if (enable && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
  endtask

  task automatic send_lines(input logic [127:0] pts);
    random_gap(send_gaps);
    s_axis_tdata_i <= pts;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_points.push_back(predict_crossing(pts));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [20:0] value);
    wait_drained();
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    threshold = value;
  endtask

  function automatic logic [127:0] pack_lines(input int ax1, ay1, ax2, ay2,
                                              input int bx1, by1, bx2, by2);
    return {16'(by2), 16'(bx2), 16'(by1), 16'(bx1), 16'(ay2), 16'(ax2), 16'(ay1), 16'(ax1)};
  endfunction

  function automatic logic [127:0] random_lines(input int span);
    logic [127:0] v;
    for (int i = 0; i < 8; i++) begin
      if (span == 0) v[16*i +: 16] = 16'($urandom);
      else v[16*i +: 16] = 16'($urandom_range(0, 2 * span) - span);
    end
    return v;
  endfunction

  always @(posedge clk_i) begin
    crossing_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_points.size() == 0) begin
        $error("unexpected result %h %b", m_axis_tdata_o, m_axis_tuser_o);
        fail_count++;
      end else begin
        want = pending_points.pop_front();
        if (m_axis_tdata_o[31:0] !== want.cross_x) begin
          $error("cross_x expected %h actual %h", want.cross_x, m_axis_tdata_o[31:0]);
          fail_count++;
        end
        if (m_axis_tdata_o[63:32] !== want.cross_y) begin
          $error("cross_y expected %h actual %h", want.cross_y, m_axis_tdata_o[63:32]);
          fail_count++;
        end
        if (m_axis_tuser_o[0] !== want.point_valid) begin
          $error("point_valid expected %b actual %b", want.point_valid, m_axis_tuser_o[0]);
          fail_count++;
        end
        if (m_axis_tuser_o[1] !== want.clipped) begin
          $error("clipped expected %b actual %b", want.clipped, m_axis_tuser_o[1]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (recv_gaps && $urandom_range(0, 9) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic test_directed();
    send_lines(pack_lines(0, 0, 2, 2, 0, 2, 2, 0));
    send_lines(pack_lines(0, 0, 1, 1, 0, 1, 1, 2));
    send_lines(pack_lines(0, 0, 1, 1, 2, 2, 3, 3));
    send_lines(pack_lines(3, 3, 3, 3, 1, 2, 5, 7));
    send_lines(pack_lines(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_lines(pack_lines(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768));
    send_lines(pack_lines(-32768, -32768, -32767, -32767, 32767, -32768, 32767, -32767));
    send_lines(pack_lines(0, 0, 3, 1, 0, 1, 3, 0));
    send_lines(pack_lines(0, 0, 3, -1, 0, -1, 3, 0));
    send_lines(pack_lines(0, 0, 1, 0, 32767, -32768, 32766, 32767));
    send_lines(pack_lines(-1, -1, -1, -1, -1, -1, -1, -1));
    send_lines(pack_lines(32767, 0, -32768, 1, 32767, 1, -32768, 0));
  endtask

  task automatic test_thresholds();
    write_threshold(21'd0);
    send_lines(pack_lines(0, 0, 1, 1, 0, 1, 1, 2));
    send_lines(pack_lines(0, 0, 1, 0, 0, 0, 0, 1));
    write_threshold(21'h100000);
    send_lines(pack_lines(0, 0, 1023, 0, 0, 0, 0, 1025));
    send_lines(pack_lines(0, 0, 1024, 0, 0, 0, 0, 1024));
    send_lines(pack_lines(0, 0, 1023, 0, 0, 0, 0, 1024));
    write_threshold(21'h1FFFFF);
    for (int i = 0; i < 10; i++) send_lines(random_lines(0));
    write_threshold(21'd1);
  endtask

  task automatic test_random(input int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) send_lines(random_lines(0));
      else if (sel < 7) send_lines(random_lines(40));
      else if (sel < 9) send_lines(random_lines(3));
      else send_lines(pack_lines(0, 0, 2, 2, $urandom_range(0, 9), 0, $urandom_range(0, 9) + 2, 2));
    end
  endtask

  initial begin
    cycle_count = 0;
    fail_count = 0;
    threshold = 21'd1;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_thresholds();
    test_random(500);
    write_threshold(21'd300);
    test_random(400);
    wait_drained();
    write_threshold(21'd0);
    test_random(400);
    write_threshold(21'd1);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random(250);
    wait_drained();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
